// ===== hdl/ppws_pkg.sv =====
// shared types, constants and codes for the pure pursuit wheel speed block
`default_nettype none

package ppws_pkg;

    // fixed point position of the speed and pose words
    localparam int FRAC_BITS = 16;

    // cell counts of the three chains
    localparam int ROOT_STEPS = 31;
    localparam int SIN_STEPS  = 30;
    localparam int KDIV_SHIFT = (2 * FRAC_BITS - 29 > 0) ? 2 * FRAC_BITS - 29 : 0;
    localparam int KDIV_STEPS = 31 + KDIV_SHIFT;
    // extra right shift of the curvature quotient, added to the v shift
    localparam int KSH_BASE   = KDIV_SHIFT - (2 * FRAC_BITS - 29);

    localparam logic [30:0] SIN_ONE = 31'h4000_0000;
    localparam logic [30:0] LIM31   = 31'h7FFF_FFFF;

    // register indexes
    localparam logic [1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] CFG_ANGLE_GAIN   = 2'd1;
    localparam logic [1:0] CFG_WHEEL_BASE   = 2'd2;

    localparam logic [15:0] TARGET_SPEED_RST = 16'd128;
    localparam logic [15:0] ANGLE_GAIN_RST   = 16'd1152;
    localparam logic [15:0] WHEEL_BASE_RST   = 16'd128;

    // turn kinds
    localparam logic [1:0] TURN_CURVE = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] heading_x;
        logic signed [31:0] heading_y;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } ppws_in_t;

    typedef struct packed {
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic [1:0]         turn_kind;
        logic               saturated;
    } ppws_out_t;

    // per item flags that ride along every cell
    typedef struct packed {
        logic        spin;
        logic        turn_left;
        logic        neg;
        logic        vv_zero;
        logic [1:0]  sv;
        logic [30:0] vn;
    } ppws_side_t;

    // square root chain word
    typedef struct packed {
        ppws_side_t  side;
        logic [61:0] abs_cross;
        logic [61:0] vrem;
        logic [61:0] vroot;
        logic [61:0] hrem;
        logic [61:0] hroot;
    } ppws_sq_t;

    // restoring divider chain word
    typedef struct packed {
        ppws_side_t  side;
        logic        over;
        logic [63:0] rem;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] quo;
    } ppws_dv_t;

endpackage

`default_nettype wire

// ===== hdl/ppws_front.sv =====
// front stages: goal vector, block normalization, products and sums
`default_nettype none

module ppws_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ppws_pkg::ppws_in_t  in_data,
    output logic                out_valid,
    output ppws_pkg::ppws_sq_t  out_data
);

    function automatic logic in_win(input logic signed [32:0] x);
        return (x[32:30] == 3'b000) || (x[32:30] == 3'b111);
    endfunction

    function automatic logic [1:0] norm_shift(input logic signed [32:0] x,
                                              input logic signed [32:0] y);
        if (in_win(x) && in_win(y))
            return 2'd0;
        if (in_win(x >>> 1) && in_win(y >>> 1))
            return 2'd1;
        if (in_win(x >>> 2) && in_win(y >>> 2))
            return 2'd2;
        return 2'd3;
    endfunction

    // stage one: difference and normalization
    logic signed [32:0] vx_full, vy_full, hx_full, hy_full;
    logic signed [32:0] vx_sh, vy_sh, hx_sh, hy_sh;
    logic [1:0]         sv_c, sh_c;
    logic               turn_left_c;

    assign vx_full = 33'(in_data.goal_x) - 33'(in_data.start_x);
    assign vy_full = 33'(in_data.goal_y) - 33'(in_data.start_y);
    assign hx_full = 33'(in_data.heading_x);
    assign hy_full = 33'(in_data.heading_y);
    assign sv_c    = norm_shift(vx_full, vy_full);
    assign sh_c    = norm_shift(hx_full, hy_full);
    assign vx_sh   = vx_full >>> sv_c;
    assign vy_sh   = vy_full >>> sv_c;
    assign hx_sh   = hx_full >>> sh_c;
    assign hy_sh   = hy_full >>> sh_c;

    // spin direction from raw signs
    assign turn_left_c =
        (!in_data.heading_x[31] && (in_data.heading_x != 32'sd0)
            && vx_full[32] && vy_full[32])
        || (in_data.heading_x[31]
            && !vx_full[32] && (vx_full != 33'sd0)
            && !vy_full[32] && (vy_full != 33'sd0));

    logic               s1_valid_reg;
    logic signed [30:0] nvx_reg, nvy_reg, nhx_reg, nhy_reg;
    logic [1:0]         s1_sv_reg;
    logic               s1_left_reg;

    // stage two: products
    logic signed [61:0] p_dx_next, p_dy_next, p_c1_next, p_c2_next;
    logic signed [61:0] p_vxx_next, p_vyy_next, p_hxx_next, p_hyy_next;

    assign p_dx_next  = nvx_reg * nhx_reg;
    assign p_dy_next  = nvy_reg * nhy_reg;
    assign p_c1_next  = nhy_reg * nvx_reg;
    assign p_c2_next  = nhx_reg * nvy_reg;
    assign p_vxx_next = nvx_reg * nvx_reg;
    assign p_vyy_next = nvy_reg * nvy_reg;
    assign p_hxx_next = nhx_reg * nhx_reg;
    assign p_hyy_next = nhy_reg * nhy_reg;

    logic               s2_valid_reg;
    logic signed [61:0] p_dx_reg, p_dy_reg, p_c1_reg, p_c2_reg;
    logic signed [61:0] p_vxx_reg, p_vyy_reg, p_hxx_reg, p_hyy_reg;
    logic [1:0]         s2_sv_reg;
    logic               s2_left_reg;

    // stage three: dot, cross and squared lengths
    logic signed [62:0]  dot_c, cross_c, cross_mag;
    logic [61:0]         vv_c, hh_c;
    ppws_pkg::ppws_sq_t  sq_next;

    assign dot_c     = 63'(p_dx_reg) + 63'(p_dy_reg);
    assign cross_c   = 63'(p_c1_reg) - 63'(p_c2_reg);
    assign cross_mag = cross_c[62] ? -cross_c : cross_c;
    assign vv_c      = $unsigned(p_vxx_reg) + $unsigned(p_vyy_reg);
    assign hh_c      = $unsigned(p_hxx_reg) + $unsigned(p_hyy_reg);

    always_comb
    begin
        sq_next                = '0;
        sq_next.side.spin      = dot_c[62];
        sq_next.side.turn_left = s2_left_reg;
        sq_next.side.neg       = cross_c[62];
        sq_next.side.vv_zero   = (vv_c == 62'd0);
        sq_next.side.sv        = s2_sv_reg;
        sq_next.abs_cross      = cross_mag[61:0];
        sq_next.vrem           = vv_c;
        sq_next.hrem           = hh_c;
    end

    logic               s3_valid_reg;
    ppws_pkg::ppws_sq_t s3_data_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nvx_reg     <= vx_sh[30:0];
            nvy_reg     <= vy_sh[30:0];
            nhx_reg     <= hx_sh[30:0];
            nhy_reg     <= hy_sh[30:0];
            s1_sv_reg   <= sv_c;
            s1_left_reg <= turn_left_c;
            p_dx_reg    <= p_dx_next;
            p_dy_reg    <= p_dy_next;
            p_c1_reg    <= p_c1_next;
            p_c2_reg    <= p_c2_next;
            p_vxx_reg   <= p_vxx_next;
            p_vyy_reg   <= p_vyy_next;
            p_hxx_reg   <= p_hxx_next;
            p_hyy_reg   <= p_hyy_next;
            s2_sv_reg   <= s1_sv_reg;
            s2_left_reg <= s1_left_reg;
            s3_data_reg <= sq_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

`default_nettype wire

// ===== hdl/ppws_sqrt_cell.sv =====
// one bit step of the two integer square roots
`default_nettype none

module ppws_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [5:0]         shift,
    input  logic               in_valid,
    input  ppws_pkg::ppws_sq_t in_data,
    output logic               out_valid,
    output ppws_pkg::ppws_sq_t out_data
);

    function automatic logic [123:0] root_step(input logic [61:0] rem,
                                               input logic [61:0] root,
                                               input logic [61:0] bitv);
        logic [61:0] trial;
        trial = root + bitv;
        if (rem >= trial)
            return {rem - trial, (root >> 1) + bitv};
        return {rem, root >> 1};
    endfunction

    logic [61:0]        bitv;
    ppws_pkg::ppws_sq_t data_next;

    assign bitv = 62'(1) << shift;

    // both roots advance one bit
    always_comb
    begin
        data_next = in_data;
        {data_next.vrem, data_next.vroot} = root_step(in_data.vrem, in_data.vroot, bitv);
        {data_next.hrem, data_next.hroot} = root_step(in_data.hrem, in_data.hroot, bitv);
    end

    logic               valid_reg;
    ppws_pkg::ppws_sq_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/ppws_div_cell.sv =====
// one quotient bit of a restoring divider
`default_nettype none

module ppws_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ppws_pkg::ppws_dv_t in_data,
    output logic               out_valid,
    output ppws_pkg::ppws_dv_t out_data
);

    logic [63:0]        shifted;
    logic               fits;
    ppws_pkg::ppws_dv_t data_next;

    // shift in the next dividend bit, subtract when it fits
    assign shifted = {in_data.rem[62:0], in_data.num[63]};
    assign fits    = (shifted >= in_data.den);

    always_comb
    begin
        data_next     = in_data;
        data_next.rem = fits ? shifted - in_data.den : shifted;
        data_next.num = {in_data.num[62:0], 1'b0};
        data_next.quo = {in_data.quo[62:0], fits};
    end

    logic               valid_reg;
    ppws_pkg::ppws_dv_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/ppws_back.sv =====
// back stages: curvature clamp, steering term, wheel speeds and output queue
`default_nettype none

module ppws_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ppws_pkg::ppws_dv_t  in_data,
    input  logic signed [15:0]  target_speed,
    input  logic [15:0]         angle_gain,
    input  logic [15:0]         wheel_base,
    output logic                en,
    output logic                out_valid,
    input  logic                out_ready,
    output ppws_pkg::ppws_out_t out_data
);

    localparam int SPEED_W = 16 + ppws_pkg::FRAC_BITS - 8 + 1;
    localparam logic signed [40:0] MAX32 = 41'sd2147483647;
    localparam logic signed [40:0] MIN32 = -MAX32 - 41'sd1;
    localparam logic [1:0] QUEUE_FULL = 2'd2;

    function automatic logic [32:0] clamp32(input logic signed [40:0] x);
        if (x > MAX32)
            return {1'b1, 32'h7FFF_FFFF};
        if (x < MIN32)
            return {1'b1, 32'h8000_0000};
        return {1'b0, x[31:0]};
    endfunction

    // speed times gain, follows the registers
    logic [15:0] abs_speed;
    logic [31:0] gs_reg;

    assign abs_speed = target_speed[15] ? 16'(-target_speed) : target_speed;

    always_ff @(posedge clk)
    begin
        gs_reg <= abs_speed * angle_gain;
    end

    // curvature from the quotient
    logic [63:0] k_quo;
    logic        k_over;

    assign k_quo  = in_data.quo >> (ppws_pkg::KSH_BASE + int'(in_data.side.sv));
    assign k_over = in_data.side.vv_zero || (k_quo > 64'(ppws_pkg::LIM31));

    logic                 k_valid_reg, a1_valid_reg, a2_valid_reg, a3_valid_reg;
    logic [30:0]          k_reg;
    logic                 k_sat_reg, a1_sat_reg, a2_sat_reg, a3_sat_reg;
    ppws_pkg::ppws_side_t k_side_reg, a1_side_reg, a2_side_reg, a3_side_reg;
    logic [62:0]          a1_prod_reg;
    logic [30:0]          a2_ang_reg;
    logic [37:0]          a3_delta_reg;

    // angular term and wheel delta
    logic [62:0] prod_next;
    logic [46:0] ang_wide;
    logic        ang_over;
    logic [46:0] delta_wide;

    assign prod_next  = gs_reg * k_reg;
    assign ang_wide   = a1_prod_reg[62:16];
    assign ang_over   = (ang_wide > 47'(ppws_pkg::LIM31));
    assign delta_wide = a2_ang_reg * wheel_base;

    // final wheel speeds
    logic signed [SPEED_W-1:0] speed_q, half;
    logic signed [39:0]        delta_s, delta_signed;
    logic                      negate;
    logic signed [40:0]        left_sum, right_sum;
    logic [32:0]               left_cl, right_cl;
    logic signed [31:0]        spin_left;
    ppws_pkg::ppws_out_t       word;

    assign speed_q      = SPEED_W'(target_speed) <<< (ppws_pkg::FRAC_BITS - 8);
    assign half         = speed_q[SPEED_W-1] ? -((-speed_q) >>> 1) : (speed_q >>> 1);
    assign negate       = target_speed[15] != a3_side_reg.neg;
    assign delta_s      = $signed({2'b00, a3_delta_reg});
    assign delta_signed = negate ? -delta_s : delta_s;
    assign left_sum     = 41'(speed_q) + 41'(delta_signed);
    assign right_sum    = 41'(speed_q) - 41'(delta_signed);
    assign left_cl      = clamp32(left_sum);
    assign right_cl     = clamp32(right_sum);
    assign spin_left    = a3_side_reg.turn_left ? 32'(-half) : 32'(half);

    always_comb
    begin
        if (a3_side_reg.spin)
        begin
            word.left_speed  = spin_left;
            word.right_speed = -spin_left;
            word.turn_kind   = a3_side_reg.turn_left ? ppws_pkg::TURN_LEFT
                                                     : ppws_pkg::TURN_RIGHT;
            word.saturated   = 1'b0;
        end
        else
        begin
            word.left_speed  = left_cl[31:0];
            word.right_speed = right_cl[31:0];
            word.turn_kind   = ppws_pkg::TURN_CURVE;
            word.saturated   = a3_sat_reg | left_cl[32] | right_cl[32];
        end
    end

    // two word output queue
    logic [1:0]          cnt_reg, cnt_next;
    ppws_pkg::ppws_out_t head_reg, head_next, skid_reg, skid_next;
    logic                push, pop;

    assign en        = (cnt_reg != QUEUE_FULL);
    assign push      = en && a3_valid_reg;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    head_next = word;
                else
                    skid_next = word;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = skid_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                head_next = word;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg  <= 1'b0;
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (en)
            begin
                k_valid_reg  <= in_valid;
                a1_valid_reg <= k_valid_reg;
                a2_valid_reg <= a1_valid_reg;
                a3_valid_reg <= a2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
        if (en)
        begin
            k_reg        <= k_over ? ppws_pkg::LIM31 : k_quo[30:0];
            k_sat_reg    <= k_over;
            k_side_reg   <= in_data.side;
            a1_prod_reg  <= prod_next;
            a1_sat_reg   <= k_sat_reg;
            a1_side_reg  <= k_side_reg;
            a2_ang_reg   <= ang_over ? ppws_pkg::LIM31 : ang_wide[30:0];
            a2_sat_reg   <= a1_sat_reg | ang_over;
            a2_side_reg  <= a1_side_reg;
            a3_delta_reg <= delta_wide[46:9];
            a3_sat_reg   <= a2_sat_reg;
            a3_side_reg  <= a2_side_reg;
        end
    end

    assign out_data = head_reg;

endmodule

`default_nettype wire

// ===== hdl/pure_pursuit_wheel_speeds.sv =====
// speed and pose words are Q16.16; one word per cycle while the queue has room
// every cell of the three chains advances together
// a two word output queue stalls the whole chain only once both entries are held
// reset: asynchronous, active low; clears all valid bits and the output queue,
// registers return to speed 128, gain 1152, wheel base 128
`default_nettype none

module pure_pursuit_wheel_speeds (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppws_pkg::ppws_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ppws_pkg::ppws_out_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int ROOT_N = ppws_pkg::ROOT_STEPS;
    localparam int SIN_N  = ppws_pkg::SIN_STEPS;
    localparam int KDIV_N = ppws_pkg::KDIV_STEPS;

    logic en;

    // configuration registers
    logic signed [15:0] target_speed_reg;
    logic [15:0]        angle_gain_reg;
    logic [15:0]        wheel_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= ppws_pkg::TARGET_SPEED_RST;
            angle_gain_reg   <= ppws_pkg::ANGLE_GAIN_RST;
            wheel_base_reg   <= ppws_pkg::WHEEL_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppws_pkg::CFG_TARGET_SPEED: target_speed_reg <= cfg_data;
                ppws_pkg::CFG_ANGLE_GAIN:   angle_gain_reg   <= cfg_data;
                ppws_pkg::CFG_WHEEL_BASE:   wheel_base_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = en;

    // front stages
    logic               sq_valid [0:ROOT_N];
    ppws_pkg::ppws_sq_t sq_data  [0:ROOT_N];

    ppws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0])
    );

    // square root chain, one result bit per cell
    for (genvar i = 0; i < ROOT_N; i++)
    begin : g_root
        ppws_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (6'(2 * (ROOT_N - 1 - i))),
            .in_valid  (sq_valid[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // length product
    logic                 m_valid_reg;
    ppws_pkg::ppws_side_t m_side_reg, m_side_next;
    logic [61:0]          m_cross_reg;
    logic [61:0]          m_b_reg, m_b_next;

    assign m_b_next = sq_data[ROOT_N].hroot[30:0] * sq_data[ROOT_N].vroot[30:0];

    always_comb
    begin
        m_side_next    = sq_data[ROOT_N].side;
        m_side_next.vn = sq_data[ROOT_N].vroot[30:0];
    end

    // integer part of the sine quotient
    logic               q_valid_reg;
    ppws_pkg::ppws_dv_t q_data_reg, q_data_next;
    logic               q_ge;

    assign q_ge = (m_cross_reg >= m_b_reg);

    always_comb
    begin
        q_data_next      = '0;
        q_data_next.side = m_side_reg;
        q_data_next.over = ({1'b0, m_cross_reg} >= {m_b_reg, 1'b0});
        q_data_next.rem  = 64'(q_ge ? m_cross_reg - m_b_reg : m_cross_reg);
        q_data_next.den  = 64'(m_b_reg);
        q_data_next.quo  = 64'(q_ge);
    end

    // sine fraction chain
    logic               sd_valid [0:SIN_N];
    ppws_pkg::ppws_dv_t sd_data  [0:SIN_N];

    assign sd_valid[0] = q_valid_reg;
    assign sd_data[0]  = q_data_reg;

    for (genvar i = 0; i < SIN_N; i++)
    begin : g_sin
        ppws_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sd_valid[i]),
            .in_data   (sd_data[i]),
            .out_valid (sd_valid[i+1]),
            .out_data  (sd_data[i+1])
        );
    end

    // clamp the sine and load the curvature divider
    logic               s_valid_reg;
    ppws_pkg::ppws_dv_t s_data_reg, s_data_next;
    logic [30:0]        sin_q, sin_val;

    assign sin_q   = sd_data[SIN_N].quo[30:0];
    assign sin_val = (sd_data[SIN_N].over || (sin_q > ppws_pkg::SIN_ONE))
                     ? ppws_pkg::SIN_ONE : sin_q;

    always_comb
    begin
        s_data_next      = '0;
        s_data_next.side = sd_data[SIN_N].side;
        s_data_next.den  = 64'(sd_data[SIN_N].side.vn);
        s_data_next.num  = {sin_val, 33'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= sq_valid[ROOT_N];
            q_valid_reg <= m_valid_reg;
            s_valid_reg <= sd_valid[SIN_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg  <= m_side_next;
            m_cross_reg <= sq_data[ROOT_N].abs_cross;
            m_b_reg     <= m_b_next;
            q_data_reg  <= q_data_next;
            s_data_reg  <= s_data_next;
        end
    end

    // curvature divider chain
    logic               kd_valid [0:KDIV_N];
    ppws_pkg::ppws_dv_t kd_data  [0:KDIV_N];

    assign kd_valid[0] = s_valid_reg;
    assign kd_data[0]  = s_data_reg;

    for (genvar i = 0; i < KDIV_N; i++)
    begin : g_kdiv
        ppws_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (kd_valid[i]),
            .in_data   (kd_data[i]),
            .out_valid (kd_valid[i+1]),
            .out_data  (kd_data[i+1])
        );
    end

    // back stages and output queue
    ppws_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (kd_valid[KDIV_N]),
        .in_data      (kd_data[KDIV_N]),
        .target_speed (target_speed_reg),
        .angle_gain   (angle_gain_reg),
        .wheel_base   (wheel_base_reg),
        .en           (en),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/ppws_checker.sv =====
// port level checks for the wheel speed block and their bind
`default_nettype none

module ppws_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input ppws_pkg::ppws_out_t out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // spins never report clipping
    a_spin_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.turn_kind != ppws_pkg::TURN_CURVE) |-> !out_data.saturated)
        else $error("spin word flagged as saturated");

    // spins turn the wheels in opposite directions at equal speed
    a_spin_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.turn_kind != ppws_pkg::TURN_CURVE)
        |-> out_data.left_speed == 32'(-out_data.right_speed))
        else $error("spin wheel speeds not symmetric");

endmodule

bind pure_pursuit_wheel_speeds ppws_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
